// ===== sv/pol_pkg.sv =====
// pol_pkg: shared sizes, codes and controller/datapath types for the
// positional ordered list. No dependencies.
package pol_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int OP_W    = 3;
  localparam int VAL_W   = 32;
  localparam int POS_W   = 5;
  localparam int ST_W    = 2;
  localparam int COUNT_W = 5;

  // compare width: holds count+1 and any position
  localparam int CMP_W = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FIRST = 3'd0,
    OP_INS_LAST  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FIRST = 3'd3,
    OP_DEL_LAST  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_READ_AT   = 3'd6,
    OP_NOP       = 3'd7
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming beat
    logic commit;   // execute held op, update list, load result
  } cmd_t;

endpackage

// ===== sv/pol_ctrl.sv =====
// pol_ctrl: handshake controller for the positional ordered list.
// Depends on pol_pkg.
module pol_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output pol_pkg::cmd_t cmd
);

  pol_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pol_pkg::S_IDLE: begin
        if (in_valid) state_nxt = pol_pkg::S_EXEC;
      end
      pol_pkg::S_EXEC: begin
        if (!out_valid_r || out_ready) state_nxt = pol_pkg::S_IDLE;
      end
      default: state_nxt = pol_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      pol_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      pol_pkg::S_EXEC: begin
        cmd.commit = !out_valid_r || out_ready;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.commit)     out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pol_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== sv/pol_dp.sv =====
// pol_dp: entry shift array, element count and result registers.
// Depends on pol_pkg.
module pol_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pol_pkg::cmd_t                    cmd,
  input  logic        [pol_pkg::OP_W-1:0]  in_operation,
  input  logic signed [pol_pkg::VAL_W-1:0] in_value,
  input  logic        [pol_pkg::POS_W-1:0] in_position,
  output logic        [pol_pkg::ST_W-1:0]  out_status,
  output logic        [pol_pkg::COUNT_W-1:0] out_element_count,
  output logic signed [pol_pkg::VAL_W-1:0] out_read_value
);

  // held beat
  pol_pkg::op_t                     op_r;
  logic signed [pol_pkg::VAL_W-1:0] val_r;
  logic        [pol_pkg::POS_W-1:0] pos_r;

  logic signed [pol_pkg::VAL_W-1:0] entries_r   [pol_pkg::CAPACITY];
  logic signed [pol_pkg::VAL_W-1:0] entries_nxt [pol_pkg::CAPACITY];
  logic [pol_pkg::CNT_W-1:0]        count_r, count_nxt;

  logic        [pol_pkg::ST_W-1:0]    status_r;
  logic        [pol_pkg::COUNT_W-1:0] ecount_r;
  logic signed [pol_pkg::VAL_W-1:0]   rdval_r;

  logic [pol_pkg::CMP_W-1:0] pos_w, cnt_w, idx;
  logic                      is_ins, is_del, is_read;
  logic                      do_ins, do_del;
  pol_pkg::status_t          status;
  logic signed [pol_pkg::VAL_W-1:0] rd;
  logic [pol_pkg::IDX_W-1:0] rd_idx;

  assign pos_w   = pol_pkg::CMP_W'(pos_r);
  assign cnt_w   = pol_pkg::CMP_W'(count_r);
  assign is_ins  = op_r inside {pol_pkg::OP_INS_FIRST, pol_pkg::OP_INS_LAST,
                                pol_pkg::OP_INS_AT};
  assign is_del  = op_r inside {pol_pkg::OP_DEL_FIRST, pol_pkg::OP_DEL_LAST,
                                pol_pkg::OP_DEL_AT};
  assign is_read = (op_r == pol_pkg::OP_READ_AT);
  assign rd_idx  = pol_pkg::IDX_W'(pos_w - pol_pkg::CMP_W'(1));

  // decode: status, target index, shift direction
  always_comb begin
    status = pol_pkg::ST_OK;
    idx    = '0;
    do_ins = 1'b0;
    do_del = 1'b0;
    rd     = '0;
    if (is_ins) begin
      if (cnt_w == pol_pkg::CMP_W'(pol_pkg::CAPACITY)) begin
        status = pol_pkg::ST_FULL;
      end else if (op_r == pol_pkg::OP_INS_FIRST) begin
        do_ins = 1'b1;
      end else if (op_r == pol_pkg::OP_INS_LAST) begin
        idx    = cnt_w;
        do_ins = 1'b1;
      end else if (pos_w == '0 || pos_w > cnt_w + pol_pkg::CMP_W'(1)) begin
        status = pol_pkg::ST_BADPOS;
      end else begin
        idx    = pos_w - pol_pkg::CMP_W'(1);
        do_ins = 1'b1;
      end
    end else if (is_del) begin
      if (cnt_w == '0) begin
        status = pol_pkg::ST_EMPTY;
      end else if (op_r == pol_pkg::OP_DEL_FIRST) begin
        do_del = 1'b1;
      end else if (op_r == pol_pkg::OP_DEL_LAST) begin
        idx    = cnt_w - pol_pkg::CMP_W'(1);
        do_del = 1'b1;
      end else if (pos_w == '0 || pos_w > cnt_w) begin
        status = pol_pkg::ST_BADPOS;
      end else begin
        idx    = pos_w - pol_pkg::CMP_W'(1);
        do_del = 1'b1;
      end
    end else if (is_read) begin
      if (cnt_w == '0)                          status = pol_pkg::ST_EMPTY;
      else if (pos_w == '0 || pos_w > cnt_w)    status = pol_pkg::ST_BADPOS;
      else                                      rd = entries_r[rd_idx];
    end
  end

  // per-entry shift: open a gap on insert, close it on delete
  for (genvar g = 0; g < pol_pkg::CAPACITY; g++) begin : g_ent
    logic signed [pol_pkg::VAL_W-1:0] lower, upper;
    if (g > 0) begin : g_lo
      assign lower = entries_r[g-1];
    end else begin : g_lo0
      assign lower = entries_r[g];
    end
    if (g < pol_pkg::CAPACITY - 1) begin : g_hi
      assign upper = entries_r[g+1];
    end else begin : g_hi0
      assign upper = entries_r[g];
    end
    always_comb begin
      entries_nxt[g] = entries_r[g];
      if (do_ins) begin
        if (pol_pkg::CMP_W'(g) == idx)     entries_nxt[g] = val_r;
        else if (pol_pkg::CMP_W'(g) > idx) entries_nxt[g] = lower;
      end else if (do_del) begin
        if (pol_pkg::CMP_W'(g) >= idx)     entries_nxt[g] = upper;
      end
    end
  end

  always_comb begin
    if (do_ins)      count_nxt = count_r + pol_pkg::CNT_W'(1);
    else if (do_del) count_nxt = count_r - pol_pkg::CNT_W'(1);
    else             count_nxt = count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= pol_pkg::op_t'(in_operation);
      val_r <= in_value;
      pos_r <= in_position;
    end
    if (cmd.commit) begin
      entries_r <= entries_nxt;
      status_r  <= status;
      ecount_r  <= pol_pkg::COUNT_W'(count_nxt);
      rdval_r   <= rd;
    end
  end

  assign out_status        = status_r;
  assign out_element_count = ecount_r;
  assign out_read_value    = rdval_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= pol_pkg::CNT_W'(pol_pkg::CAPACITY))
    else $error("count above capacity");

  a_cnt_ins: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && do_ins |=> count_r == $past(count_r) + pol_pkg::CNT_W'(1))
    else $error("insert did not grow count");

  a_cnt_del: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && do_del |=> count_r == $past(count_r) - pol_pkg::CNT_W'(1))
    else $error("delete did not shrink count");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.commit |=> $stable(count_r))
    else $error("count moved without commit");

endmodule

// ===== sv/positional_ordered_list.sv =====
// positional_ordered_list: top level, joins controller and datapath.
// Depends on pol_pkg, pol_ctrl, pol_dp.
//
// Bounded ordered list of up to CAPACITY (16) signed 32-bit values. Each
// input beat carries an operation (insert first/last/at, delete
// first/last/at, read at) and gives exactly one result beat with a status
// (ok, invalid position, full, empty), the count after the operation and the
// value read (zero unless a read succeeded). Failed operations leave the
// list untouched; code 7 is a no-op that returns ok. Each beat is first
// latched; then, in the execute state, every entry shifts in parallel around
// the target position and the result register loads. A new beat is taken
// while the previous result still waits; the execute state stalls only if
// that result has not been taken yet. No clearing pass after reset: only
// entries below the count are ever read.
module positional_ordered_list (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic        [pol_pkg::OP_W-1:0]    in_operation,
  input  logic signed [pol_pkg::VAL_W-1:0]   in_value,
  input  logic        [pol_pkg::POS_W-1:0]   in_position,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic        [pol_pkg::ST_W-1:0]    out_status,
  output logic        [pol_pkg::COUNT_W-1:0] out_element_count,
  output logic signed [pol_pkg::VAL_W-1:0]   out_read_value
);

  pol_pkg::cmd_t cmd;

  // handshake sequencing
  pol_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // list storage, decode and result registers
  pol_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_operation      (in_operation),
    .in_value          (in_value),
    .in_position       (in_position),
    .out_status        (out_status),
    .out_element_count (out_element_count),
    .out_read_value    (out_read_value)
  );

endmodule

// ===== sim/tb_top.sv =====
// tb_top: self-checking testbench for positional_ordered_list.
// Depends on pol_pkg and the positional_ordered_list RTL. Clocked driver and
// monitor, with an in-bench mirror of the list that predicts every result beat.
`timescale 1ns / 1ps

module tb_top;
  import pol_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1250;
  localparam int TAIL_CYCLES  = 20;

  // one list command as it goes onto the input channel
  typedef struct {
    op_t                     op;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
    bit                      wait_idle;  // hold off until every result is back
  } list_cmd_t;

  // one result beat as the list should produce it
  typedef struct {
    status_t                 status;
    logic [COUNT_W-1:0]      count;
    logic signed [VAL_W-1:0] rd;
  } list_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [OP_W-1:0]           in_operation = '0;
  logic signed [VAL_W-1:0]   in_value = '0;
  logic [POS_W-1:0]          in_position = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [ST_W-1:0]           out_status;
  logic [COUNT_W-1:0]        out_element_count;
  logic signed [VAL_W-1:0]   out_read_value;

  list_cmd_t               pending_ops[$];   // commands not yet driven
  list_result_t            results_due[$];   // predicted beats, oldest first
  logic signed [VAL_W-1:0] list_mirror[$];   // bench copy of the list contents

  logic in_fire = 1'b0;   // input beat taken at the last rising edge
  int   in_gap = 0;
  bit   in_burst = 1'b0;
  int   out_stall = 0;
  bit   out_burst = 1'b0;
  int   errors = 0;
  int   cycles = 0;

  positional_ordered_list dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_element_count(out_element_count),
    .out_read_value   (out_read_value)
  );

  always #5 clk = ~clk;

  // Apply one command to the mirror and return the beat the block should give.
  // Full is checked before position on inserts, empty before position on
  // deletes and reads; failed commands leave the mirror alone. Code 7 is a nop.
  function automatic list_result_t list_apply(op_t op, logic signed [VAL_W-1:0] value,
                                              logic [POS_W-1:0] position);
    list_result_t r;
    int n;
    int p;
    n = list_mirror.size();
    p = int'(position);
    r.status = ST_OK;
    r.rd = '0;
    case (op)
      OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
        if (n >= CAPACITY) r.status = ST_FULL;
        else if (op == OP_INS_FIRST) list_mirror.push_front(value);
        else if (op == OP_INS_LAST) list_mirror.push_back(value);
        else if (p < 1 || p > n + 1) r.status = ST_BADPOS;
        else list_mirror.insert(p - 1, value);
      end
      OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT: begin
        if (n == 0) r.status = ST_EMPTY;
        else if (op == OP_DEL_FIRST) void'(list_mirror.pop_front());
        else if (op == OP_DEL_LAST) void'(list_mirror.pop_back());
        else if (p < 1 || p > n) r.status = ST_BADPOS;
        else list_mirror.delete(p - 1);
      end
      OP_READ_AT: begin
        if (n == 0) r.status = ST_EMPTY;
        else if (p < 1 || p > n) r.status = ST_BADPOS;
        else r.rd = list_mirror[p - 1];
      end
      default: ;
    endcase
    r.count = COUNT_W'(list_mirror.size());
    return r;
  endfunction

  // Idle length: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  task automatic add_cmd(op_t op, logic signed [VAL_W-1:0] value, int position,
                         bit wait_idle = 1'b0);
    list_cmd_t c;
    c.op = op;
    c.value = value;
    c.position = POS_W'(position);
    c.wait_idle = wait_idle;
    pending_ops.push_back(c);
  endtask

  // Driver: everything changes on the falling edge. A presented beat holds
  // until the monitor saw it taken; then an optional gap, then the next one.
  // A command marked wait_idle is not presented while results are outstanding.
  always @(negedge clk) begin : drive
    list_cmd_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (in_valid && !in_fire) begin
        // beat still waiting for in_ready, keep it steady
      end else if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap = in_gap - 1;
      end else if (pending_ops.size() != 0 &&
                   !(pending_ops[0].wait_idle && results_due.size() != 0)) begin
        c = pending_ops.pop_front();
        in_valid <= 1'b1;
        in_operation <= c.op;
        in_value <= c.value;
        in_position <= c.position;
        in_gap = in_burst ? 0 : idle_len();
        if ($urandom_range(0, 19) == 0) in_burst = !in_burst;
      end else begin
        in_valid <= 1'b0;
      end

      // result side: random stalls, with back-to-back stretches in burst mode
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall = out_stall - 1;
      end else begin
        out_ready <= 1'b1;
        if (!out_burst && $urandom_range(0, 3) == 0) out_stall = idle_len();
        if ($urandom_range(0, 49) == 0) out_burst = !out_burst;
      end
    end
  end

  // Monitor: samples on the rising edge. Accepted input beats go through the
  // mirror first, then any result beat is checked against the oldest prediction.
  always @(posedge clk) begin : watch
    list_result_t want;
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still due", $time, results_due.size());
      $display("tb_top failed");
      $finish;
    end else begin
      in_fire <= rst_n && in_valid && in_ready;
      if (rst_n && in_valid && in_ready)
        results_due.push_back(list_apply(op_t'(in_operation), in_value, in_position));
      if (rst_n && out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: result beat with nothing expected: status %0d count %0d value %0d",
                   $time, out_status, out_element_count, out_read_value);
          errors = errors + 1;
        end else begin
          want = results_due.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, out_status);
            errors = errors + 1;
          end
          if (out_element_count !== want.count) begin
            $display("%0t: element count expected %0d got %0d",
                     $time, want.count, out_element_count);
            errors = errors + 1;
          end
          if (out_read_value !== want.rd) begin
            $display("%0t: read value expected %0d got %0d", $time, want.rd, out_read_value);
            errors = errors + 1;
          end
        end
      end
    end
  end

  initial begin : stimulus
    int seg_left;
    int mode;
    int ins_w;
    int del_w;
    int r;
    int pos;
    op_t op;
    logic signed [VAL_W-1:0] v;

    // Directed: empty list first (empty wins over a bad position), bad insert
    // positions, inserts at every place with the extreme values, then fill up
    // and hit the full case from all three inserts, then bad and edge reads and
    // deletes on a full list, and the unused code.
    add_cmd(OP_DEL_FIRST, 0, 0);
    add_cmd(OP_DEL_LAST, 0, 0);
    add_cmd(OP_DEL_AT, 0, 1);
    add_cmd(OP_DEL_AT, 0, 0);
    add_cmd(OP_READ_AT, 0, 1);
    add_cmd(OP_INS_AT, 5, 0);
    add_cmd(OP_INS_AT, 5, 2);
    add_cmd(OP_INS_AT, 32'sh8000_0000, 1);
    add_cmd(OP_INS_FIRST, 32'sh7FFF_FFFF, 0);
    add_cmd(OP_INS_LAST, -1, 0);
    add_cmd(OP_INS_AT, 0, 2);          // middle
    add_cmd(OP_INS_AT, $urandom, 5);   // one past the end
    for (int i = 0; i < 11; i++)
      add_cmd(op_t'($urandom_range(0, 1)), $urandom, 0);
    add_cmd(OP_INS_FIRST, 1, 0);
    add_cmd(OP_INS_LAST, 1, 0);
    add_cmd(OP_INS_AT, 1, 0);          // full is reported ahead of the bad position
    add_cmd(OP_READ_AT, 0, 16);
    add_cmd(OP_READ_AT, 0, 17);
    add_cmd(OP_READ_AT, 0, 31);
    add_cmd(OP_DEL_AT, 0, 17);
    add_cmd(OP_DEL_AT, 0, 16);
    add_cmd(OP_DEL_AT, 0, 5);
    add_cmd(OP_DEL_FIRST, 0, 0);
    add_cmd(OP_DEL_LAST, 0, 0);
    add_cmd(op_t'(3'b111), -1, 31);

    // Random: segments that lean toward filling, draining or a mix, so the
    // count sweeps between empty and full many times. Positions mostly land
    // in 1..16, the rest anywhere in the 5-bit range.
    seg_left = 0;
    mode = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(15, 60);
        mode = $urandom_range(0, 2);
      end
      seg_left = seg_left - 1;
      ins_w = (mode == 0) ? 70 : (mode == 1) ? 20 : 40;
      del_w = (mode == 0) ? 15 : (mode == 1) ? 65 : 35;
      r = $urandom_range(0, 99);
      if (r < ins_w) op = op_t'($urandom_range(0, 2));
      else if (r < ins_w + del_w) op = op_t'($urandom_range(3, 5));
      else if (r < 97) op = OP_READ_AT;
      else op = OP_NOP;
      pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
      case ($urandom_range(0, 19))
        0: v = 32'sh8000_0000;
        1: v = 32'sh7FFF_FFFF;
        2: v = -1;
        3: v = 0;
        default: v = $urandom;
      endcase
      add_cmd(op, v, pos, (i % 300) == 0);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // settle past the falling-edge updates before looking at the queues
    do begin
      @(negedge clk);
      #1;
    end while (pending_ops.size() != 0 || in_valid || results_due.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/pol_pkg.sv
sv/pol_ctrl.sv
sv/pol_dp.sv
sv/positional_ordered_list.sv
sim/tb_top.sv
